// File: rtl/hcb_pkg.sv
// hcb_pkg: shared constants, codes and the control/status structs of the huffman code builder
// used by hcb_ctrl, hcb_dp and huffman_code_builder_codec; depends on nothing
package hcb_pkg;

  localparam int ALPHA         = 256;
  localparam int COUNT_BITS    = 16;
  localparam int MAX_CODE_BITS = 32;

  localparam int NODE_TOTAL = 2 * ALPHA - 1;
  localparam int NW         = $clog2(NODE_TOTAL);
  localparam int SW         = $clog2(ALPHA);
  localparam int WB         = 24;
  localparam int LW         = 6;
  localparam int CB         = 32;
  localparam int PW         = LW + CB;

  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_COUNT  = 3'd1;
  localparam logic [2:0] ACT_BUILD  = 3'd2;
  localparam logic [2:0] ACT_ENCODE = 3'd3;
  localparam logic [2:0] ACT_DECODE = 3'd4;

  localparam logic [1:0] ST_BUILT  = 2'd0;
  localparam logic [1:0] ST_CODE   = 2'd1;
  localparam logic [1:0] ST_SYMBOL = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_cnt;
    logic cnt_rd;
    logic cnt_wr;
    logic init_start;
    logic init_rd;
    logic init_wr;
    logic build_fail;
    logic scan_start;
    logic scan;
    logic kill_a;
    logic kill_b;
    logic make_node;
    logic code_start;
    logic cd_rd;
    logic cd_w0;
    logic cd_w1;
    logic build_ok;
    logic enc_rd;
    logic enc_res;
    logic dec_err;
    logic dec_rd;
    logic dec_res;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic any_leaf;
    logic scan_done;
    logic pair_found;
    logic code_done;
    logic dec_ok;
    logic dec_leaf;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/huffman_code_builder_codec.sv
// huffman_code_builder_codec: clear, count, encode and decode are each one accepted transfer,
// and in_stall holds off the next one until it is done; a result waits on out_stall. Build first
// copies the 256 histogram counts into leaf weights, then per merge reads one weight store entry
// per node index below the merge limit, then reads and writes the code paths of each internal
// node from the root down, one node at a time
// synchronous active-low reset clears the histogram valid bits, tree state and output valid
module huffman_code_builder_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_symbol,
  input  logic        in_bit_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_code_bits,
  output logic [5:0]  out_code_length,
  output logic [7:0]  out_decoded_symbol
);

  hcb_pkg::cmd_t  cmd;
  hcb_pkg::stat_t stat;

  hcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hcb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_symbol          (in_symbol),
    .in_bit_value       (in_bit_value),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_code_bits      (out_code_bits),
    .out_code_length    (out_code_length),
    .out_decoded_symbol (out_decoded_symbol)
  );

endmodule

// File: rtl/hcb_ctrl.sv
// hcb_ctrl: sequencer for clear, count, build, encode and decode actions
// drives hcb_dp through hcb_pkg::cmd_t and reads hcb_pkg::stat_t
module hcb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_action,
  output logic               in_stall,
  input  hcb_pkg::stat_t     stat,
  output hcb_pkg::cmd_t      cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_CNT_RD    = 5'd1;
  localparam logic [4:0] S_CNT_WR    = 5'd2;
  localparam logic [4:0] S_INIT_RD   = 5'd3;
  localparam logic [4:0] S_INIT_WR   = 5'd4;
  localparam logic [4:0] S_INIT_END  = 5'd5;
  localparam logic [4:0] S_SCAN      = 5'd6;
  localparam logic [4:0] S_KILL_A    = 5'd7;
  localparam logic [4:0] S_KILL_B    = 5'd8;
  localparam logic [4:0] S_MAKE      = 5'd9;
  localparam logic [4:0] S_CODE_ROOT = 5'd10;
  localparam logic [4:0] S_CD_LOOP   = 5'd11;
  localparam logic [4:0] S_CD_W0     = 5'd12;
  localparam logic [4:0] S_CD_W1     = 5'd13;
  localparam logic [4:0] S_BUILD_OK  = 5'd14;
  localparam logic [4:0] S_ENC_RD    = 5'd15;
  localparam logic [4:0] S_ENC_RES   = 5'd16;
  localparam logic [4:0] S_DEC_RD    = 5'd17;
  localparam logic [4:0] S_DEC_RES   = 5'd18;
  localparam logic [4:0] S_EMIT      = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (in_action)
            hcb_pkg::ACT_CLEAR:  cmd.clr_cnt = 1'b1;
            hcb_pkg::ACT_COUNT:  state_nxt = S_CNT_RD;
            hcb_pkg::ACT_BUILD: begin
              cmd.init_start = 1'b1;
              state_nxt      = S_INIT_RD;
            end
            hcb_pkg::ACT_ENCODE: state_nxt = S_ENC_RD;
            hcb_pkg::ACT_DECODE: state_nxt = S_DEC_RD;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_INIT_RD: begin
        cmd.init_rd = 1'b1;
        state_nxt   = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        state_nxt   = stat.init_last ? S_INIT_END : S_INIT_RD;
      end
      S_INIT_END: begin
        if (stat.any_leaf) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.build_fail = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = stat.pair_found ? S_KILL_A : S_CODE_ROOT;
        end
      end
      S_KILL_A: begin
        cmd.kill_a = 1'b1;
        state_nxt  = S_KILL_B;
      end
      S_KILL_B: begin
        cmd.kill_b = 1'b1;
        state_nxt  = S_MAKE;
      end
      S_MAKE: begin
        cmd.make_node  = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_CODE_ROOT: begin
        cmd.code_start = 1'b1;
        state_nxt      = S_CD_LOOP;
      end
      S_CD_LOOP: begin
        if (stat.code_done) begin
          state_nxt = S_BUILD_OK;
        end else begin
          cmd.cd_rd = 1'b1;
          state_nxt = S_CD_W0;
        end
      end
      S_CD_W0: begin
        cmd.cd_w0 = 1'b1;
        state_nxt = S_CD_W1;
      end
      S_CD_W1: begin
        cmd.cd_w1 = 1'b1;
        state_nxt = S_CD_LOOP;
      end
      S_BUILD_OK: begin
        cmd.build_ok = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_ENC_RD: begin
        cmd.enc_rd = 1'b1;
        state_nxt  = S_ENC_RES;
      end
      S_ENC_RES: begin
        cmd.enc_res = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_DEC_RD: begin
        if (stat.dec_ok) begin
          cmd.dec_rd = 1'b1;
          state_nxt  = S_DEC_RES;
        end else begin
          cmd.dec_err = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_DEC_RES: begin
        cmd.dec_res = 1'b1;
        state_nxt   = stat.dec_leaf ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/hcb_dp.sv
// hcb_dp: histogram, node weight, children and path memories, merge scan and result register
// uses hcb_pkg constants and structs; commanded by hcb_ctrl
module hcb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hcb_pkg::cmd_t          cmd,
  output hcb_pkg::stat_t         stat,
  input  logic [7:0]             in_symbol,
  input  logic                   in_bit_value,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [31:0]            out_code_bits,
  output logic [5:0]             out_code_length,
  output logic [7:0]             out_decoded_symbol
);

  localparam int NW = hcb_pkg::NW;
  localparam int SW = hcb_pkg::SW;
  localparam int WB = hcb_pkg::WB;
  localparam int LW = hcb_pkg::LW;
  localparam int CB = hcb_pkg::CB;
  localparam int PW = hcb_pkg::PW;
  localparam int CNTB = hcb_pkg::COUNT_BITS;
  localparam logic [NW-1:0] ALPHA_N = NW'(hcb_pkg::ALPHA);
  localparam logic [CNTB-1:0] COUNT_MAX = '1;
  localparam logic [LW-1:0] LEN_CAP = '1;
  localparam logic [LW-1:0] LEN_MAX = LW'(hcb_pkg::MAX_CODE_BITS);

  // input latch
  logic [7:0] sym_r;
  logic       bit_r;
  logic       sym_ok;
  logic [SW-1:0] sym_idx;

  // histogram
  logic [CNTB-1:0] cnt_mem [hcb_pkg::ALPHA];
  logic [hcb_pkg::ALPHA-1:0] cnt_vld_r;
  logic [CNTB-1:0] cnt_q_r;
  logic            cnt_qv_r;
  logic [CNTB-1:0] cnt_cur, cnt_wd;
  logic            cnt_re, cnt_we;
  logic [SW-1:0]   cnt_ra;

  // node weights with live flag on top
  logic [WB:0]     wt_mem [hcb_pkg::NODE_TOTAL];
  logic [WB:0]     wt_q_r;
  logic            wt_we;
  logic [NW-1:0]   wt_wa;
  logic [WB:0]     wt_wd;
  logic [WB-1:0]   leaf_w;
  logic [WB:0]     wsum;
  logic [WB-1:0]   wnew;

  logic [hcb_pkg::ALPHA-1:0] leaf_vld_r;
  logic [NW-1:0]   idx_r, rd_idx_r, limit;
  logic            rd_v_r, scan_issue, any_leaf_r;
  logic [NW-1:0]   best_r, sec_r;
  logic [WB-1:0]   best_w_r, sec_w_r;
  logic            best_v_r, sec_v_r;
  logic [SW-1:0]   made_r, k_r, k_m1;

  // children
  logic [2*NW-1:0] ch_mem [hcb_pkg::ALPHA];
  logic [2*NW-1:0] ch_q_r;
  logic [SW-1:0]   ch_ra;
  logic [NW-1:0]   cur_off, nxt;

  // paths
  logic [PW-1:0]   p_mem [hcb_pkg::NODE_TOTAL];
  logic [PW-1:0]   pq_r;
  logic            p_re, p_we;
  logic [NW-1:0]   p_ra, p_wa;
  logic [PW-1:0]   p_wd;
  logic [LW-1:0]   pq_len, len_n;
  logic [CB-1:0]   pq_bits;

  logic            tree_built_r, enc_ok_r;
  logic [NW-1:0]   root_r, cursor_r;

  // pending result and output register
  logic [1:0]      res_st_r;
  logic [CB-1:0]   res_bits_r;
  logic [LW-1:0]   res_len_r;
  logic [7:0]      res_sym_r;
  logic            out_valid_r;

  assign sym_ok  = ({1'b0, sym_r} < 9'(hcb_pkg::ALPHA));
  assign sym_idx = sym_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r <= in_symbol;
      bit_r <= in_bit_value;
    end
  end

  // histogram
  assign cnt_re  = cmd.cnt_rd | cmd.init_rd;
  assign cnt_ra  = cmd.init_rd ? idx_r[SW-1:0] : sym_idx;
  assign cnt_cur = cnt_qv_r ? cnt_q_r : '0;
  assign cnt_wd  = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign cnt_we  = cmd.cnt_wr && sym_ok;

  always_ff @(posedge clk) begin
    if (cnt_re) begin
      cnt_q_r  <= cnt_mem[cnt_ra];
      cnt_qv_r <= cnt_vld_r[cnt_ra];
    end
    if (cnt_we) begin
      cnt_mem[sym_idx] <= cnt_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cmd.clr_cnt) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[sym_idx] <= 1'b1;
    end
  end

  // node weights
  assign leaf_w = WB'(cnt_cur);
  assign wsum   = {1'b0, best_w_r} + {1'b0, sec_w_r};
  assign wnew   = wsum[WB] ? '1 : wsum[WB-1:0];
  assign limit  = ALPHA_N + NW'(made_r);
  assign scan_issue = (idx_r < limit);

  always_comb begin
    wt_we = 1'b1;
    wt_wa = idx_r;
    wt_wd = {(leaf_w != '0), leaf_w};
    if (cmd.kill_a) begin
      wt_wa = best_r;
      wt_wd = {1'b0, best_w_r};
    end else if (cmd.kill_b) begin
      wt_wa = sec_r;
      wt_wd = {1'b0, sec_w_r};
    end else if (cmd.make_node) begin
      wt_wa = limit;
      wt_wd = {1'b1, wnew};
    end else if (!cmd.init_wr) begin
      wt_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_issue) begin
      wt_q_r <= wt_mem[idx_r];
    end
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      leaf_vld_r[idx_r[SW-1:0]] <= (leaf_w != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      idx_r      <= '0;
      any_leaf_r <= 1'b0;
      made_r     <= '0;
    end else if (cmd.init_wr) begin
      idx_r      <= idx_r + 1'b1;
      any_leaf_r <= any_leaf_r | (leaf_w != '0);
    end else if (cmd.scan_start) begin
      idx_r    <= '0;
      rd_v_r   <= 1'b0;
      best_v_r <= 1'b0;
      sec_v_r  <= 1'b0;
    end else if (cmd.scan) begin
      rd_v_r   <= scan_issue;
      rd_idx_r <= idx_r;
      if (scan_issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rd_v_r && wt_q_r[WB]) begin
        if (!best_v_r || (wt_q_r[WB-1:0] < best_w_r)) begin
          sec_r    <= best_r;
          sec_w_r  <= best_w_r;
          sec_v_r  <= best_v_r;
          best_r   <= rd_idx_r;
          best_w_r <= wt_q_r[WB-1:0];
          best_v_r <= 1'b1;
        end else if (!sec_v_r || (wt_q_r[WB-1:0] < sec_w_r)) begin
          sec_r   <= rd_idx_r;
          sec_w_r <= wt_q_r[WB-1:0];
          sec_v_r <= 1'b1;
        end
      end
    end
    if (cmd.make_node) begin
      made_r <= made_r + 1'b1;
    end
  end

  // children
  assign k_m1    = k_r - 1'b1;
  assign cur_off = cursor_r - ALPHA_N;
  assign ch_ra   = cmd.cd_rd ? k_m1 : cur_off[SW-1:0];
  assign nxt     = bit_r ? ch_q_r[2*NW-1:NW] : ch_q_r[NW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cd_rd || cmd.dec_rd) begin
      ch_q_r <= ch_mem[ch_ra];
    end
    if (cmd.make_node) begin
      ch_mem[made_r] <= {sec_r, best_r};
    end
  end

  // paths
  assign pq_len  = pq_r[PW-1:CB];
  assign pq_bits = pq_r[CB-1:0];
  assign len_n   = (pq_len == LEN_CAP) ? pq_len : pq_len + 1'b1;
  assign p_re    = cmd.cd_rd | cmd.enc_rd;
  assign p_ra    = cmd.cd_rd ? (ALPHA_N + NW'(k_m1)) : NW'(sym_idx);
  assign p_we    = cmd.code_start | cmd.cd_w0 | cmd.cd_w1;

  always_comb begin
    p_wa = best_r;
    p_wd = '0;
    if (cmd.cd_w0) begin
      p_wa = ch_q_r[NW-1:0];
      p_wd = {len_n, pq_bits[CB-2:0], 1'b0};
    end else if (cmd.cd_w1) begin
      p_wa = ch_q_r[2*NW-1:NW];
      p_wd = {len_n, pq_bits[CB-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (p_re) begin
      pq_r <= p_mem[p_ra];
    end
    if (p_we) begin
      p_mem[p_wa] <= p_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code_start) begin
      k_r <= made_r;
    end else if (cmd.cd_w1) begin
      k_r <= k_m1;
    end
    if (cmd.enc_rd) begin
      enc_ok_r <= tree_built_r && sym_ok && leaf_vld_r[sym_idx];
    end
  end

  // tree registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_built_r <= 1'b0;
      root_r       <= '0;
      cursor_r     <= '0;
    end else begin
      if (cmd.init_start) begin
        tree_built_r <= 1'b0;
      end else if (cmd.build_ok) begin
        tree_built_r <= 1'b1;
      end
      if (cmd.code_start) begin
        root_r <= best_r;
      end
      if (cmd.build_ok) begin
        cursor_r <= root_r;
      end else if (cmd.dec_res) begin
        cursor_r <= stat.dec_leaf ? root_r : nxt;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.build_fail || cmd.dec_err || (cmd.enc_res && !(enc_ok_r && pq_len <= LEN_MAX))) begin
      res_st_r   <= hcb_pkg::ST_ERROR;
      res_bits_r <= '0;
      res_len_r  <= '0;
      res_sym_r  <= '0;
    end else if (cmd.enc_res) begin
      res_st_r   <= hcb_pkg::ST_CODE;
      res_bits_r <= pq_bits;
      res_len_r  <= pq_len;
      res_sym_r  <= '0;
    end else if (cmd.build_ok) begin
      res_st_r   <= hcb_pkg::ST_BUILT;
      res_bits_r <= '0;
      res_len_r  <= '0;
      res_sym_r  <= '0;
    end else if (cmd.dec_res) begin
      res_st_r   <= hcb_pkg::ST_SYMBOL;
      res_bits_r <= '0;
      res_len_r  <= '0;
      res_sym_r  <= nxt[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status         <= res_st_r;
      out_code_bits      <= res_bits_r;
      out_code_length    <= res_len_r;
      out_decoded_symbol <= res_sym_r;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.init_last  = (idx_r == NW'(hcb_pkg::ALPHA - 1));
  assign stat.any_leaf   = any_leaf_r;
  assign stat.scan_done  = !scan_issue && !rd_v_r;
  assign stat.pair_found = sec_v_r;
  assign stat.code_done  = (k_r == '0);
  assign stat.dec_ok     = tree_built_r && (root_r >= ALPHA_N) && (cursor_r >= ALPHA_N);
  assign stat.dec_leaf   = (nxt < ALPHA_N);
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

// File: sim/tb_huffman_code_builder_codec.sv
// tb_huffman_code_builder_codec: self-checking testbench for the byte huffman code builder
// predicts every result with its own histogram, tree and code table model
// depends on hcb_pkg and huffman_code_builder_codec
module tb_huffman_code_builder_codec;

  localparam int ALPHA         = hcb_pkg::ALPHA;
  localparam int NODE_TOTAL    = hcb_pkg::NODE_TOTAL;
  localparam int COUNT_BITS    = hcb_pkg::COUNT_BITS;
  localparam int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS;
  localparam logic [2:0] ACT_CLEAR  = hcb_pkg::ACT_CLEAR;
  localparam logic [2:0] ACT_COUNT  = hcb_pkg::ACT_COUNT;
  localparam logic [2:0] ACT_BUILD  = hcb_pkg::ACT_BUILD;
  localparam logic [2:0] ACT_ENCODE = hcb_pkg::ACT_ENCODE;
  localparam logic [2:0] ACT_DECODE = hcb_pkg::ACT_DECODE;
  localparam logic [1:0] ST_BUILT   = hcb_pkg::ST_BUILT;
  localparam logic [1:0] ST_CODE    = hcb_pkg::ST_CODE;
  localparam logic [1:0] ST_SYMBOL  = hcb_pkg::ST_SYMBOL;
  localparam logic [1:0] ST_ERROR   = hcb_pkg::ST_ERROR;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] code;
    logic [5:0]  len;
    logic [7:0]  sym;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [7:0]  in_symbol;
  logic        in_bit_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_code_bits;
  logic [5:0]  out_code_length;
  logic [7:0]  out_decoded_symbol;

  huffman_code_builder_codec i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_symbol(in_symbol), .in_bit_value(in_bit_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_code_bits(out_code_bits), .out_code_length(out_code_length),
    .out_decoded_symbol(out_decoded_symbol)
  );

  // model of the block
  int unsigned hist[ALPHA];
  int unsigned weight[NODE_TOTAL];
  int unsigned kid[ALPHA-1][2];
  logic [31:0] code_tab[ALPHA];
  int unsigned len_tab[ALPHA];
  bit          leaf_ok[ALPHA];
  bit          live[NODE_TOTAL];
  logic [31:0] pbits[NODE_TOTAL];
  int unsigned plen[NODE_TOTAL];
  int unsigned root;
  int unsigned cursor;
  bit          have_tree;

  answer_t     expected_q[$];
  int          errors;
  int          sent;
  int          checked;
  int          builds;
  int          decodes;
  int          snd_pct;
  int          rcv_pct;
  int          hold_cycles;
  longint      cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned take_lightest();
    int unsigned best;
    best = NODE_TOTAL;
    for (int i = 0; i < NODE_TOTAL; i++)
      if (live[i] && (best == NODE_TOTAL || weight[i] < weight[best])) best = i;
    if (best < NODE_TOTAL) live[best] = 0;
    return best;
  endfunction

  function automatic answer_t build_tree();
    answer_t     r;
    int unsigned leaves, made, a, b, n, w, p, c, d;
    r = '{ST_BUILT, 0, 0, 0};
    leaves = 0;
    made = 0;
    for (int i = 0; i < NODE_TOTAL; i++) live[i] = 0;
    for (int s = 0; s < ALPHA; s++) begin
      leaf_ok[s] = 0;
      if (hist[s] != 0) begin
        live[s] = 1;
        weight[s] = hist[s];
        leaf_ok[s] = 1;
        leaves++;
      end
    end
    have_tree = 0;
    if (leaves == 0) begin
      r.status = ST_ERROR;
      return r;
    end
    forever begin
      a = take_lightest();
      b = take_lightest();
      if (b >= NODE_TOTAL || made >= ALPHA - 1) break;
      n = ALPHA + made;
      w = weight[a] + weight[b];
      weight[n] = (w > 24'hffffff) ? 24'hffffff : w;
      kid[made][0] = a;
      kid[made][1] = b;
      live[n] = 1;
      made++;
    end
    root = a;
    pbits[root] = 0;
    plen[root] = 0;
    for (int k = made; k > 0; k--) begin
      p = ALPHA + k - 1;
      for (int bt = 0; bt < 2; bt++) begin
        c = kid[k-1][bt];
        d = plen[p] + 1;
        pbits[c] = (pbits[p] << 1) | bt;
        plen[c] = (d > 63) ? 63 : d;
      end
    end
    for (int s = 0; s < ALPHA; s++)
      if (leaf_ok[s]) begin
        code_tab[s] = pbits[s];
        len_tab[s] = plen[s];
      end
    have_tree = 1;
    cursor = root;
    return r;
  endfunction

  // returns 1 when the transfer produces a result
  function automatic bit predict(input logic [2:0] act, input logic [7:0] s,
                                 input logic bv, output answer_t r);
    int unsigned nxt;
    r = '{ST_ERROR, 0, 0, 0};
    case (act)
      ACT_CLEAR: begin
        for (int i = 0; i < ALPHA; i++) hist[i] = 0;
        return 0;
      end
      ACT_COUNT: begin
        if (hist[s] < (1 << COUNT_BITS) - 1) hist[s]++;
        return 0;
      end
      ACT_BUILD: begin
        r = build_tree();
        return 1;
      end
      ACT_ENCODE: begin
        if (have_tree && leaf_ok[s] && len_tab[s] <= MAX_CODE_BITS)
          r = '{ST_CODE, code_tab[s], len_tab[s], 0};
        return 1;
      end
      ACT_DECODE: begin
        if (!have_tree || root < ALPHA || cursor < ALPHA || cursor >= NODE_TOTAL) return 1;
        nxt = kid[cursor-ALPHA][bv];
        if (nxt < ALPHA) begin
          cursor = root;
          r = '{ST_SYMBOL, 0, 0, nxt[7:0]};
          return 1;
        end
        cursor = nxt;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report(input string what);
    $display("mismatch %0s at cycle %0d", what, cycles);
    errors++;
  endtask

  task automatic send(input logic [2:0] act, input logic [7:0] s, input logic bv);
    answer_t r;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_symbol <= s;
    in_bit_value <= bv;
    do @(posedge clk); while (in_stall);
    sent++;
    if (act == ACT_BUILD) builds++;
    if (act == ACT_DECODE) decodes++;
    if (predict(act, s, bv, r)) expected_q.push_back(r);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // walk a symbol's code bit by bit, most significant used bit first
  task automatic decode_symbol(input logic [7:0] s);
    for (int i = len_tab[s] - 1; i >= 0; i--) send(ACT_DECODE, 0, code_tab[s][i]);
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report("unexpected result");
      else begin
        e = expected_q.pop_front();
        checked++;
        if (out_status !== e.status) report("status");
        if (out_code_bits !== e.code) report("code_bits");
        if (out_code_length !== e.len) report("code_length");
        if (out_decoded_symbol !== e.sym) report("decoded_symbol");
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < rcv_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("timeout with %0d results pending", expected_q.size());
      $display("[huffman_code_builder_codec] ERROR");
      $finish;
    end
  end

  task automatic test_no_tree();
    send(ACT_ENCODE, 8'h00, 0);
    send(ACT_DECODE, 8'h00, 1);
    send(ACT_BUILD, 8'h00, 0);
    send(ACT_ENCODE, 8'hff, 0);
  endtask

  task automatic test_lone_symbol();
    send(ACT_COUNT, 8'hff, 0);
    send(ACT_COUNT, 8'hff, 0);
    send(ACT_BUILD, 0, 0);
    send(ACT_ENCODE, 8'hff, 0);
    send(ACT_ENCODE, 8'h00, 0);
    send(ACT_DECODE, 0, 0);
    send(ACT_DECODE, 0, 1);
  endtask

  task automatic test_small_tree();
    // equal weights exercise the tie rule; clear must leave the tree intact
    send(ACT_CLEAR, 0, 0);
    send(ACT_COUNT, 8'h00, 0);
    send(ACT_COUNT, 8'haa, 0);
    send(ACT_COUNT, 8'h55, 0);
    send(ACT_COUNT, 8'h55, 0);
    send(ACT_BUILD, 0, 0);
    send(3'd5, 8'h55, 1);
    send(3'd6, 8'haa, 0);
    send(3'd7, 8'hff, 1);
    send(ACT_CLEAR, 0, 0);
    send(ACT_ENCODE, 8'h55, 0);
    send(ACT_ENCODE, 8'haa, 0);
    decode_symbol(8'h00);
    decode_symbol(8'h55);
  endtask

  task automatic test_full_alphabet();
    send(ACT_CLEAR, 0, 0);
    for (int s = 0; s < ALPHA; s++) send(ACT_COUNT, s[7:0], 0);
    send(ACT_COUNT, 8'h80, 0);
    send(ACT_BUILD, 0, 0);
    for (int i = 0; i < 6; i++) send(ACT_ENCODE, 8'($urandom_range(255)), 0);
    decode_symbol(8'h80);
    decode_symbol(8'($urandom_range(255)));
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    for (int i = 0; i < 40; i++)
      send(i % 2 ? ACT_ENCODE : ACT_DECODE, 8'($urandom_range(255)),
           1'($urandom_range(1)));
    drain();
  endtask

  task automatic random_session();
    logic [7:0] set[$];
    int         nsym, pick;
    logic [7:0] s;
    send(ACT_CLEAR, 0, 0);
    pick = $urandom_range(99);
    nsym = pick < 5 ? 0 : pick < 15 ? 1 : $urandom_range(10, 2);
    for (int i = 0; i < nsym; i++) set.push_back(8'($urandom_range(255)));
    for (int i = 0; i < nsym * $urandom_range(4, 1); i++)
      send(ACT_COUNT, set[$urandom_range(nsym - 1)], 1'($urandom_range(1)));
    send(ACT_BUILD, 8'($urandom_range(255)), 1'($urandom_range(1)));
    for (int i = $urandom_range(25, 10); i > 0; i--) begin
      pick = $urandom_range(99);
      s = (nsym > 0 && $urandom_range(9) < 7) ? set[$urandom_range(nsym - 1)]
                                               : 8'($urandom_range(255));
      if (pick < 50) send(ACT_ENCODE, s, 1'($urandom_range(1)));
      else if (pick < 90) begin
        if (leaf_ok[s] && have_tree) decode_symbol(s);
        else send(ACT_DECODE, s, 1'($urandom_range(1)));
      end else send(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      snd_pct = phase == 0 ? 23 : phase == 1 ? 73 : 0;
      rcv_pct = phase == 0 ? 73 : phase == 1 ? 23 : 0;
      while (sent < 500 * (phase + 1) + 50) random_session();
    end
  endtask

  initial begin
    errors = 0; sent = 0; checked = 0; builds = 0; decodes = 0;
    cycles = 0; hold_cycles = 0; snd_pct = 0; rcv_pct = 0;
    for (int i = 0; i < ALPHA; i++) begin
      hist[i] = 0; leaf_ok[i] = 0; code_tab[i] = 0; len_tab[i] = 0;
    end
    for (int i = 0; i < NODE_TOTAL; i++) begin
      weight[i] = 0; live[i] = 0; pbits[i] = 0; plen[i] = 0;
    end
    for (int i = 0; i < ALPHA - 1; i++) kid[i] = '{0, 0};
    root = 0; cursor = 0; have_tree = 0;
    rst_n = 0;
    in_valid = 0;
    in_action = ACT_CLEAR;
    in_symbol = 0;
    in_bit_value = 0;
    out_stall = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_no_tree();
    test_lone_symbol();
    test_small_tree();
    snd_pct = 10; rcv_pct = 30;
    test_full_alphabet();
    test_backpressure();
    test_random();
    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d transfers, %0d builds and %0d decode steps; %0d results checked",
             sent, builds, decodes, checked);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[huffman_code_builder_codec] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("[huffman_code_builder_codec] ERROR");
    end
    $finish;
  end

endmodule
